>>> rtl/heightmap_cell_triangulator_defines.svh
// Assertion macros used by the triangulator RTL.
`ifndef HEIGHTMAP_CELL_TRIANGULATOR_DEFINES_SVH
`define HEIGHTMAP_CELL_TRIANGULATOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define HTRI_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked at the same clock edge.
`define HTRI_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`endif

>>> rtl/htri_pkg.sv
// Types, constants and helper functions of the heightmap cell triangulator.
package htri_pkg;

  // commands
  localparam logic [2:0] CMD_SURFACE = 3'd0;
  localparam logic [2:0] CMD_TOP     = 3'd1;
  localparam logic [2:0] CMD_BOTTOM  = 3'd2;
  localparam logic [2:0] CMD_LEFT    = 3'd3;
  localparam logic [2:0] CMD_RIGHT   = 3'd4;
  localparam logic [2:0] CMD_FLOOR   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;
  localparam logic [1:0] REG_STEP_X    = 2'd2;
  localparam logic [1:0] REG_STEP_Y    = 2'd3;

  // result word kinds
  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_V1     = 2'd1;
  localparam logic [1:0] KIND_V2     = 2'd2;
  localparam logic [1:0] KIND_V3     = 2'd3;

  localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
  localparam logic signed [32:0] COORD_LO = -33'sd8388608;
  localparam logic signed [32:0] COORD_HI = 33'sd268435455;

  // buffering
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int CNT_W      = 5;

  // normal datapath widths
  localparam int MAG_W      = 41;
  localparam int SMAG_W     = 31;
  localparam int RAD_W      = 64;
  localparam int LEN_W      = 32;
  localparam int NUM_W      = 46;
  localparam int QUO_W      = 15;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;

  typedef logic signed [28:0] coord_t;
  typedef logic signed [15:0] ncomp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic [2:0]       cmd;
    point_t [3:0]     pts;
  } point_rec_t;

  typedef struct packed {
    ncomp_t x;
    ncomp_t y;
    ncomp_t z;
  } normal_t;

  typedef struct packed {
    normal_t n1;
    normal_t n0;
  } normal_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  // magnitudes and signs of both cross products riding beside the root cells
  typedef struct packed {
    logic                          v;
    logic [2:0]                    neg_a;
    logic [2:0]                    neg_b;
    logic [2:0][SMAG_W-1:0]        mag_a;
    logic [2:0][SMAG_W-1:0]        mag_b;
  } norm_tag_t;

  function automatic coord_t sat_coord(input logic signed [32:0] v);
    coord_t r;
    if (v < COORD_LO) r = COORD_LO[28:0];
    else if (v > COORD_HI) r = COORD_HI[28:0];
    else r = v[28:0];
    return r;
  endfunction

  function automatic logic [1:0] pick3(input logic [1:0] a, input logic [1:0] b,
                                       input logic [1:0] c, input logic [1:0] kind);
    logic [1:0] r;
    case (kind)
      KIND_V1: r = a;
      KIND_V2: r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  // which of the four corner points a vertex word carries
  function automatic logic [1:0] vertex_sel(input logic [2:0] cmd, input logic facet,
                                            input logic [1:0] kind);
    logic [1:0] r;
    case (cmd)
      CMD_SURFACE: r = facet ? pick3(2'd0, 2'd1, 2'd3, kind) : pick3(2'd0, 2'd3, 2'd2, kind);
      CMD_TOP:     r = facet ? pick3(2'd1, 2'd3, 2'd2, kind) : pick3(2'd1, 2'd0, 2'd3, kind);
      CMD_BOTTOM:  r = facet ? pick3(2'd0, 2'd2, 2'd3, kind) : pick3(2'd0, 2'd1, 2'd2, kind);
      CMD_LEFT:    r = facet ? pick3(2'd0, 2'd1, 2'd2, kind) : pick3(2'd0, 2'd2, 2'd3, kind);
      CMD_RIGHT:   r = facet ? pick3(2'd3, 2'd2, 2'd1, kind) : pick3(2'd0, 2'd3, 2'd1, kind);
      default:     r = facet ? pick3(2'd1, 2'd3, 2'd2, kind) : pick3(2'd0, 2'd1, 2'd2, kind);
    endcase
    return r;
  endfunction

  function automatic normal_t axis_normal(input logic [2:0] cmd);
    normal_t r;
    r = '0;
    case (cmd)
      CMD_TOP:    r.y = UNIT_Q14;
      CMD_BOTTOM: r.y = -UNIT_Q14;
      CMD_LEFT:   r.x = -UNIT_Q14;
      CMD_RIGHT:  r.x = UNIT_Q14;
      default:    r.z = -UNIT_Q14;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/htri_channels.sv
// Handshake channel interfaces of the heightmap cell triangulator.
interface htri_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

interface htri_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [11:0]        row_index;
  logic [11:0]        col_index;
  logic signed [23:0] elev_here;
  logic signed [23:0] elev_next;
  logic signed [23:0] elev_up;
  logic signed [23:0] elev_up_next;
  modport source(output valid, output cmd, output row_index, output col_index,
                 output elev_here, output elev_next, output elev_up, output elev_up_next,
                 input ready);
  modport sink(input valid, input cmd, input row_index, input col_index,
               input elev_here, input elev_next, input elev_up, input elev_up_next,
               output ready);
endinterface

interface htri_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic               facet_number;
  logic signed [28:0] x_value;
  logic signed [28:0] y_value;
  logic signed [28:0] z_value;
  logic               last_item;
  modport source(output valid, output item_kind, output facet_number, output x_value,
                 output y_value, output z_value, output last_item, input ready);
  modport sink(input valid, input item_kind, input facet_number, input x_value,
               input y_value, input z_value, input last_item, output ready);
endinterface

>>> rtl/htri_sqrt_cell.sv
// One cell of the integer square root chain: settles one root bit per cycle.
module htri_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                       clk,
  input  logic [htri_pkg::RAD_W-1:0] v_in,
  input  logic [htri_pkg::RAD_W-1:0] r_in,
  output logic [htri_pkg::RAD_W-1:0] v_out,
  output logic [htri_pkg::RAD_W-1:0] r_out
);
  import htri_pkg::*;

  localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * STEP);

  logic [RAD_W:0]   trial;
  logic [RAD_W-1:0] v_nx;
  logic [RAD_W-1:0] r_nx;

  always_comb begin
    trial = {1'b0, r_in} + {1'b0, BIT};
    if ({1'b0, v_in} >= trial) begin
      v_nx = v_in - trial[RAD_W-1:0];
      r_nx = (r_in >> 1) + BIT;
    end else begin
      v_nx = v_in;
      r_nx = r_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    v_out <= v_nx;
    r_out <= r_nx;
  end
endmodule

>>> rtl/htri_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit per cycle.
module htri_div_cell #(
  parameter int STEP = 0
) (
  input  logic                       clk,
  input  logic [htri_pkg::NUM_W-1:0] num_in,
  input  logic [htri_pkg::LEN_W-1:0] den_in,
  input  logic [htri_pkg::QUO_W-1:0] quo_in,
  output logic [htri_pkg::NUM_W-1:0] num_out,
  output logic [htri_pkg::LEN_W-1:0] den_out,
  output logic [htri_pkg::QUO_W-1:0] quo_out
);
  import htri_pkg::*;

  logic [NUM_W-1:0] trial;
  logic [NUM_W-1:0] num_nx;
  logic [QUO_W-1:0] quo_nx;

  always_comb begin
    trial = NUM_W'(den_in) << STEP;
    if (num_in >= trial) begin
      num_nx = num_in - trial;
      quo_nx = quo_in | (QUO_W'(1) << STEP);
    end else begin
      num_nx = num_in;
      quo_nx = quo_in;
    end
  end

  always_ff @(posedge clk) begin
    num_out <= num_nx;
    den_out <= den_in;
    quo_out <= quo_nx;
  end
endmodule

>>> rtl/htri_fifo.sv
// Small first-in first-out buffer built from a register array.
module htri_fifo #(
  parameter int W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [W-1:0]           wdata,
  input  logic                   pop,
  output logic [W-1:0]           rdata,
  output htri_pkg::fifo_status_t stat
);
  import htri_pkg::*;

  logic [W-1:0]       mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [CNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + FIFO_AW'(1);
      if (pop) rptr <= rptr + FIFO_AW'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign rdata      = mem[rptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(FIFO_DEPTH));
endmodule

>>> rtl/heightmap_cell_triangulator.sv
// Throughput: one result word per cycle on results while results.ready is high, eight words per command;
//   the 16-command point and normal buffers keep that rate across the root/divide chains.
// A new command is taken every cycle while fewer than 16 commands are in flight.
// Reset (rst, synchronous, active high) empties all buffers and the chains and sets
//   grid_rows = grid_cols = 256 and step_x = step_y = 1.0 (Q8.8).
`include "heightmap_cell_triangulator_defines.svh"

module heightmap_cell_triangulator #(
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  htri_cfg_if.sink    cfg,
  htri_in_if.sink     items,
  htri_out_if.source  results
);
  import htri_pkg::*;

  localparam logic [16:0] MAX_R = 17'(MAX_ROWS);
  localparam logic [16:0] MAX_C = 17'(MAX_COLS);

  typedef struct packed {
    logic       v;
    logic [5:0] neg;
  } sign_tag_t;

  // ---------------------------------------------------------------- config
  logic [12:0] grid_rows;
  logic [12:0] grid_cols;
  logic [15:0] step_x;
  logic [15:0] step_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 13'd256;
      grid_cols <= 13'd256;
      step_x    <= 16'd256;
      step_y    <= 16'd256;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_GRID_ROWS: grid_rows <= cfg.data[12:0];
        REG_GRID_COLS: grid_cols <= cfg.data[12:0];
        REG_STEP_X:    step_x    <= cfg.data;
        REG_STEP_Y:    step_y    <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective grid size, clamped to [2, MAX]
  logic [12:0] nr;
  logic [12:0] nc;

  always_comb begin
    if (grid_rows < 13'd2) nr = 13'd2;
    else if ({4'd0, grid_rows} > MAX_R) nr = MAX_R[12:0];
    else nr = grid_rows;
    if (grid_cols < 13'd2) nc = 13'd2;
    else if ({4'd0, grid_cols} > MAX_C) nc = MAX_C[12:0];
    else nc = grid_cols;
  end

  // ---------------------------------------------------------------- credits
  // Commands in flight, from accept until their last word is loaded.
  logic [CNT_W-1:0] inflight;
  logic             take;
  logic             cmd_ok;
  logic             done_cmd;

  assign items.ready = (inflight < CNT_W'(FIFO_DEPTH));
  assign take        = items.valid && items.ready;
  assign cmd_ok      = (items.cmd <= CMD_FLOOR);   // cmd 6 and 7 are dropped

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(take && cmd_ok) - CNT_W'(done_cmd);
    end
  end

  // ---------------------------------------------------------------- S1: capture
  logic               s1_v;
  logic [2:0]         s1_cmd;
  logic [11:0]        s1_i;
  logic [11:0]        s1_j;
  logic signed [23:0] s1_eh, s1_en, s1_eu, s1_eun;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else s1_v <= take && cmd_ok;
    s1_cmd <= items.cmd;
    s1_i   <= items.row_index;
    s1_j   <= items.col_index;
    s1_eh  <= items.elev_here;
    s1_en  <= items.elev_next;
    s1_eu  <= items.elev_up;
    s1_eun <= items.elev_up_next;
  end

  // ---------------------------------------------------------------- S2: differences
  // Cross products reduce to:
  //   c0 = ( dy*(up-upnext), -dx*(up-here), dx*dy )
  //   c1 = (-dy*(next-here),  dx*(next-upnext), dx*dy )
  logic signed [24:0] d_a0x, d_a0y, d_b1x, d_b1y;

  always_comb begin
    d_a0x = {s1_eu[23], s1_eu} - {s1_eun[23], s1_eun};
    d_a0y = {s1_eu[23], s1_eu} - {s1_eh[23], s1_eh};
    d_b1x = {s1_en[23], s1_en} - {s1_eh[23], s1_eh};
    d_b1y = {s1_en[23], s1_en} - {s1_eun[23], s1_eun};
  end

  logic               s2_v;
  logic [2:0]         s2_cmd;
  logic [11:0]        s2_j;
  logic signed [13:0] s2_row;     // nr-1-i
  logic [12:0]        s2_nr1;
  logic [12:0]        s2_nc1;
  logic [24:0]        s2_abs [4];
  logic [3:0]         s2_neg;     // a.x, a.y, b.x, b.y
  logic signed [23:0] s2_eh, s2_en, s2_eu, s2_eun;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else s2_v <= s1_v;
    s2_cmd    <= s1_cmd;
    s2_j      <= s1_j;
    s2_row    <= $signed({1'b0, nr}) - 14'sd1 - $signed({2'b00, s1_i});
    s2_nr1    <= nr - 13'd1;
    s2_nc1    <= nc - 13'd1;
    s2_abs[0] <= d_a0x[24] ? 25'(-d_a0x) : 25'(d_a0x);
    s2_abs[1] <= d_a0y[24] ? 25'(-d_a0y) : 25'(d_a0y);
    s2_abs[2] <= d_b1x[24] ? 25'(-d_b1x) : 25'(d_b1x);
    s2_abs[3] <= d_b1y[24] ? 25'(-d_b1y) : 25'(d_b1y);
    s2_neg[0] <= d_a0x[24];
    s2_neg[1] <= !d_a0y[24] && (d_a0y != '0);
    s2_neg[2] <= !d_b1x[24] && (d_b1x != '0);
    s2_neg[3] <= d_b1y[24];
    s2_eh     <= s1_eh;
    s2_en     <= s1_en;
    s2_eu     <= s1_eu;
    s2_eun    <= s1_eun;
  end

  // ---------------------------------------------------------------- S3: products
  logic               s3_v;
  logic [2:0]         s3_cmd;
  logic [27:0]        s3_xa;
  logic [28:0]        s3_xm;
  logic signed [30:0] s3_ya;
  logic [28:0]        s3_ym;
  logic [MAG_W-1:0]   s3_mag [4];
  logic [MAG_W-1:0]   s3_magz;
  logic [3:0]         s3_neg;
  logic signed [23:0] s3_eh, s3_en, s3_eu, s3_eun;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else s3_v <= s2_v;
    s3_cmd    <= s2_cmd;
    s3_xa     <= {16'd0, s2_j} * {12'd0, step_x};
    s3_xm     <= {16'd0, s2_nc1} * {13'd0, step_x};
    s3_ya     <= $signed({{17{s2_row[13]}}, s2_row}) * $signed({15'd0, step_y});
    s3_ym     <= {16'd0, s2_nr1} * {13'd0, step_y};
    s3_mag[0] <= {25'd0, step_y} * {16'd0, s2_abs[0]};
    s3_mag[1] <= {25'd0, step_x} * {16'd0, s2_abs[1]};
    s3_mag[2] <= {25'd0, step_y} * {16'd0, s2_abs[2]};
    s3_mag[3] <= {25'd0, step_x} * {16'd0, s2_abs[3]};
    s3_magz   <= {25'd0, step_x} * {25'd0, step_y};
    s3_neg    <= s2_neg;
    s3_eh     <= s2_eh;
    s3_en     <= s2_en;
    s3_eu     <= s2_eu;
    s3_eun    <= s2_eun;
  end

  // ---------------------------------------------------------------- S4: corners
  coord_t     x_a, x_b, x_m, y_a, y_b, y_c, y_m;
  coord_t     z_h, z_n, z_u, z_un;
  point_rec_t pt_wdata;

  always_comb begin
    x_a  = sat_coord($signed({5'd0, s3_xa}));
    x_b  = sat_coord($signed({5'd0, s3_xa}) + $signed({17'd0, step_x}));
    x_m  = sat_coord($signed({4'd0, s3_xm}));
    y_a  = sat_coord($signed({{2{s3_ya[30]}}, s3_ya}));
    y_b  = sat_coord($signed({{2{s3_ya[30]}}, s3_ya}) + $signed({17'd0, step_y}));
    y_c  = sat_coord($signed({{2{s3_ya[30]}}, s3_ya}) - $signed({17'd0, step_y}));
    y_m  = sat_coord($signed({4'd0, s3_ym}));
    z_h  = {{5{s3_eh[23]}}, s3_eh};
    z_n  = {{5{s3_en[23]}}, s3_en};
    z_u  = {{5{s3_eu[23]}}, s3_eu};
    z_un = {{5{s3_eun[23]}}, s3_eun};
    pt_wdata.cmd = s3_cmd;
    case (s3_cmd)
      CMD_SURFACE: begin
        pt_wdata.pts[0] = {x_a, y_a, z_h};
        pt_wdata.pts[1] = {x_b, y_a, z_n};
        pt_wdata.pts[2] = {x_a, y_b, z_u};
        pt_wdata.pts[3] = {x_b, y_b, z_un};
      end
      CMD_TOP: begin
        pt_wdata.pts[0] = {x_a, y_m, 29'sd0};
        pt_wdata.pts[1] = {x_b, y_m, 29'sd0};
        pt_wdata.pts[2] = {x_b, y_m, z_n};
        pt_wdata.pts[3] = {x_a, y_m, z_h};
      end
      CMD_BOTTOM: begin
        pt_wdata.pts[0] = {x_a, 29'sd0, 29'sd0};
        pt_wdata.pts[1] = {x_b, 29'sd0, 29'sd0};
        pt_wdata.pts[2] = {x_b, 29'sd0, z_n};
        pt_wdata.pts[3] = {x_a, 29'sd0, z_h};
      end
      CMD_LEFT: begin
        pt_wdata.pts[0] = {29'sd0, y_a, 29'sd0};
        pt_wdata.pts[1] = {29'sd0, y_c, 29'sd0};
        pt_wdata.pts[2] = {29'sd0, y_c, z_n};
        pt_wdata.pts[3] = {29'sd0, y_a, z_h};
      end
      CMD_RIGHT: begin
        pt_wdata.pts[0] = {x_m, y_a, 29'sd0};
        pt_wdata.pts[1] = {x_m, y_c, 29'sd0};
        pt_wdata.pts[2] = {x_m, y_c, z_n};
        pt_wdata.pts[3] = {x_m, y_a, z_h};
      end
      default: begin
        pt_wdata.pts[0] = {29'sd0, 29'sd0, 29'sd0};
        pt_wdata.pts[1] = {29'sd0, y_m, 29'sd0};
        pt_wdata.pts[2] = {x_m, 29'sd0, 29'sd0};
        pt_wdata.pts[3] = {x_m, y_m, 29'sd0};
      end
    endcase
  end

  // ---------------------------------------------------------------- S4: scale down
  // Shift both magnitude sets right until the largest is below 2^31.
  logic [MAG_W-1:0]  lane_m [2][3];
  logic [MAG_W-1:0]  lane_or [2];
  logic [3:0]        lane_sh [2];
  logic [SMAG_W-1:0] lane_s [2][3];

  always_comb begin
    lane_m[0][0] = s3_mag[0];
    lane_m[0][1] = s3_mag[1];
    lane_m[0][2] = s3_magz;
    lane_m[1][0] = s3_mag[2];
    lane_m[1][1] = s3_mag[3];
    lane_m[1][2] = s3_magz;
    for (int l = 0; l < 2; l++) begin
      lane_or[l] = lane_m[l][0] | lane_m[l][1] | lane_m[l][2];
      lane_sh[l] = 4'd0;
      for (int b = SMAG_W; b < MAG_W; b++) begin
        if (lane_or[l][b]) lane_sh[l] = 4'(b - SMAG_W + 1);
      end
      for (int k = 0; k < 3; k++) begin
        lane_s[l][k] = SMAG_W'(lane_m[l][k] >> lane_sh[l]);
      end
    end
  end

  // side line carrying magnitudes and signs alongside the squares, sum and root cells
  localparam int TAG_LEN = SQRT_STEPS + 2;
  norm_tag_t tagl [TAG_LEN + 1];
  norm_tag_t tag_in;

  always_comb begin
    tag_in.v     = s3_v && !rst;
    tag_in.neg_a = {1'b0, s3_neg[1], s3_neg[0]};
    tag_in.neg_b = {1'b0, s3_neg[3], s3_neg[2]};
    for (int k = 0; k < 3; k++) begin
      tag_in.mag_a[k] = lane_s[0][k];
      tag_in.mag_b[k] = lane_s[1][k];
    end
  end

  always_ff @(posedge clk) begin
    tagl[0] <= tag_in;
    for (int t = 1; t <= TAG_LEN; t++) begin
      tagl[t] <= {tagl[t-1].v && !rst, tagl[t-1].neg_a, tagl[t-1].neg_b,
                  tagl[t-1].mag_a, tagl[t-1].mag_b};
    end
  end

  // ---------------------------------------------------------------- S5/S6: sum of squares
  logic [2*SMAG_W-1:0] s5_sq [2][3];
  logic [RAD_W-1:0]    s6_sum [2];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s5_sq[0][k] <= {{SMAG_W{1'b0}}, tagl[0].mag_a[k]} * {{SMAG_W{1'b0}}, tagl[0].mag_a[k]};
      s5_sq[1][k] <= {{SMAG_W{1'b0}}, tagl[0].mag_b[k]} * {{SMAG_W{1'b0}}, tagl[0].mag_b[k]};
    end
    for (int l = 0; l < 2; l++) begin
      s6_sum[l] <= RAD_W'(s5_sq[l][0]) + RAD_W'(s5_sq[l][1]) + RAD_W'(s5_sq[l][2]);
    end
  end

  // ---------------------------------------------------------------- root chain
  logic [RAD_W-1:0] rt_v [2][SQRT_STEPS + 1];
  logic [RAD_W-1:0] rt_r [2][SQRT_STEPS + 1];

  for (genvar l = 0; l < 2; l++) begin : g_root_lane
    assign rt_v[l][0] = s6_sum[l];
    assign rt_r[l][0] = '0;
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root_cell
      htri_sqrt_cell #(.STEP(k)) u_cell (
        .clk   (clk),
        .v_in  (rt_v[l][k]),
        .r_in  (rt_r[l][k]),
        .v_out (rt_v[l][k+1]),
        .r_out (rt_r[l][k+1])
      );
    end
  end

  // ---------------------------------------------------------------- S7: dividends
  // component = round(|c| * 16384 / len) = floor((|c|*2^14 + len/2) / len)
  logic [LEN_W-1:0] len [2];
  logic [NUM_W-1:0] s7_num [6];
  logic [LEN_W-1:0] s7_den [6];
  sign_tag_t        stag [DIV_STEPS + 1];

  assign len[0] = rt_r[0][SQRT_STEPS][LEN_W-1:0];
  assign len[1] = rt_r[1][SQRT_STEPS][LEN_W-1:0];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s7_num[k]   <= NUM_W'({tagl[TAG_LEN].mag_a[k], 14'd0}) + NUM_W'(len[0] >> 1);
      s7_num[k+3] <= NUM_W'({tagl[TAG_LEN].mag_b[k], 14'd0}) + NUM_W'(len[1] >> 1);
      s7_den[k]   <= len[0];
      s7_den[k+3] <= len[1];
    end
    stag[0] <= {tagl[TAG_LEN].v && !rst, tagl[TAG_LEN].neg_b, tagl[TAG_LEN].neg_a};
    for (int t = 1; t <= DIV_STEPS; t++) begin
      stag[t] <= {stag[t-1].v && !rst, stag[t-1].neg};
    end
  end

  // ---------------------------------------------------------------- divider chain
  logic [NUM_W-1:0] dv_num [6][DIV_STEPS + 1];
  logic [LEN_W-1:0] dv_den [6][DIV_STEPS + 1];
  logic [QUO_W-1:0] dv_quo [6][DIV_STEPS + 1];

  for (genvar c = 0; c < 6; c++) begin : g_div_lane
    assign dv_num[c][0] = s7_num[c];
    assign dv_den[c][0] = s7_den[c];
    assign dv_quo[c][0] = '0;
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_cell
      htri_div_cell #(.STEP(DIV_STEPS - 1 - k)) u_cell (
        .clk     (clk),
        .num_in  (dv_num[c][k]),
        .den_in  (dv_den[c][k]),
        .quo_in  (dv_quo[c][k]),
        .num_out (dv_num[c][k+1]),
        .den_out (dv_den[c][k+1]),
        .quo_out (dv_quo[c][k+1])
      );
    end
  end

  // a zero length (zero spacing) gives a zero normal
  ncomp_t      comp [6];
  normal_rec_t nrm_wdata;

  always_comb begin
    for (int c = 0; c < 6; c++) begin
      if (dv_den[c][DIV_STEPS] == '0) comp[c] = '0;
      else if (stag[DIV_STEPS].neg[c]) comp[c] = -$signed({1'b0, dv_quo[c][DIV_STEPS]});
      else comp[c] = $signed({1'b0, dv_quo[c][DIV_STEPS]});
    end
    nrm_wdata.n0 = {comp[0], comp[1], comp[2]};
    nrm_wdata.n1 = {comp[3], comp[4], comp[5]};
  end

  // ---------------------------------------------------------------- buffers
  logic         pt_push;
  logic         nrm_push;
  logic         buf_pop;
  point_rec_t   pt_head;
  normal_rec_t  nrm_head;
  fifo_status_t pt_stat;
  fifo_status_t nrm_stat;

  assign pt_push  = s3_v;
  assign nrm_push = stag[DIV_STEPS].v;

  htri_fifo #(.W($bits(point_rec_t))) u_pt_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (pt_push),
    .wdata (pt_wdata),
    .pop   (buf_pop),
    .rdata (pt_head),
    .stat  (pt_stat)
  );

  htri_fifo #(.W($bits(normal_rec_t))) u_nrm_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (nrm_push),
    .wdata (nrm_wdata),
    .pop   (buf_pop),
    .rdata (nrm_head),
    .stat  (nrm_stat)
  );

  // ---------------------------------------------------------------- output words
  // word counter: bit 2 is the facet, bits 1:0 the kind
  logic [2:0] word_cnt;
  logic       load;
  logic       out_valid;
  normal_t    nsel;
  point_t     psel;
  logic [1:0] w_kind;
  logic       w_facet;

  assign load     = !nrm_stat.empty && (!out_valid || results.ready);
  assign done_cmd = load && (word_cnt == 3'd7);
  assign buf_pop  = done_cmd;
  assign w_kind   = word_cnt[1:0];
  assign w_facet  = word_cnt[2];

  always_comb begin
    if (pt_head.cmd == CMD_SURFACE) nsel = w_facet ? nrm_head.n1 : nrm_head.n0;
    else nsel = axis_normal(pt_head.cmd);
    psel = pt_head.pts[vertex_sel(pt_head.cmd, w_facet, w_kind)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      word_cnt  <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      word_cnt  <= word_cnt + 3'd1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      results.item_kind    <= w_kind;
      results.facet_number <= w_facet;
      results.last_item    <= (word_cnt == 3'd7);
      if (w_kind == KIND_NORMAL) begin
        results.x_value <= {{13{nsel.x[15]}}, nsel.x};
        results.y_value <= {{13{nsel.y[15]}}, nsel.y};
        results.z_value <= {{13{nsel.z[15]}}, nsel.z};
      end else begin
        results.x_value <= psel.x;
        results.y_value <= psel.y;
        results.z_value <= psel.z;
      end
    end
  end

  assign results.valid = out_valid;

  // ---------------------------------------------------------------- checks
  `HTRI_ASSERT_ALWAYS(a_credit_bound, inflight <= CNT_W'(FIFO_DEPTH), "in-flight count overran")
  `HTRI_ASSERT_IMPL(a_pt_room, pt_push, !pt_stat.full, "point buffer overflow")
  `HTRI_ASSERT_IMPL(a_nrm_room, nrm_push, !nrm_stat.full, "normal buffer overflow")
  `HTRI_ASSERT_IMPL(a_last_word, results.valid && results.last_item,
                    results.item_kind == KIND_V3 && results.facet_number,
                    "last word flagged out of place")

endmodule
